>>> hw/rtl/edf_pkg.sv
// shared types and field widths of the edf job scheduler
package edf_pkg;

   localparam int TASK_W = 4;
   localparam int WORK_W = 16;
   localparam int TICK_W = 32;

   // one request beat
   typedef struct packed {
      logic              func;
      logic [TASK_W-1:0] task_id;
      logic [WORK_W-1:0] work_ticks;
      logic [TICK_W-1:0] abs_deadline;
   } req_type;

   // one response beat
   typedef struct packed {
      logic [TASK_W-1:0] served_task;
      logic              idle;
      logic              job_done;
      logic              late;
      logic              rejected;
   } rsp_type;

   // one stored job slot
   typedef struct packed {
      logic [TASK_W-1:0] task_id;
      logic [WORK_W-1:0] remaining;
      logic [TICK_W-1:0] deadline;
      logic [TICK_W-1:0] release_tick;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   // request function codes
   localparam logic FUNC_RELEASE = 1'b0;
   localparam logic FUNC_TICK    = 1'b1;

   // control from the sequencer to the compare unit
   typedef struct packed {
      logic start;
      logic cand_on;
   } pick_ctl_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_FREE = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

endpackage

>>> hw/rtl/edf_ram.sv
// generic single write port, single read port ram with registered read
module edf_ram #(
   parameter int WIDTH = 84,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/edf_pick.sv
// shared deadline compare unit that keeps the best candidate of a scan
module edf_pick #(
   parameter int IDX_W = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  edf_pkg::pick_ctl_type ctl,
   input  logic [IDX_W-1:0]      cand_idx,
   input  edf_pkg::slot_type     cand,
   output logic                  best_found,
   output logic [IDX_W-1:0]      best_idx,
   output edf_pkg::slot_type     best_slot
);

   logic                  found_ff;
   logic                  found_in;
   logic [IDX_W-1:0]      idx_ff;
   logic [IDX_W-1:0]      idx_in;
   edf_pkg::slot_type     slot_ff;
   edf_pkg::slot_type     slot_in;
   logic                  earlier;
   logic                  take;

   // strict order on deadline then release tick, so ties keep the lower slot
   assign earlier = {cand.deadline, cand.release_tick} <
                    {slot_ff.deadline, slot_ff.release_tick};
   assign take    = ctl.cand_on && (!found_ff || earlier);

   // best candidate update
   always_comb begin
      found_in = found_ff;
      idx_in   = idx_ff;
      slot_in  = slot_ff;
      if (ctl.start) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         idx_in   = cand_idx;
         slot_in  = cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      idx_ff  <= idx_in;
      slot_ff <= slot_in;
   end

   assign best_found = found_ff;
   assign best_idx   = idx_ff;
   assign best_slot  = slot_ff;

endmodule

>>> hw/rtl/edf_job_scheduler.sv
// edf job scheduler top level: sequencer, slot valid bits, slot ram, tick counter
// a release beat examines one valid bit per cycle, from slot 0 up to the lowest free one
// a tick beat feeds one slot per cycle through the ram read port
//   into the shared deadline compare unit, then updates the chosen slot and responds
// one beat is worked on at a time; the response register frees the input side
// reset clears the valid bits, the tick counter and the sequencer at once; slot ram is not cleared
module edf_job_scheduler #(
   parameter int JOB_SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  edf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output edf_pkg::rsp_type rsp_data
);

   localparam int IW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(JOB_SLOTS - 1);

   edf_pkg::state_type            state_ff;
   edf_pkg::state_type            state_in;
   logic [IW-1:0]                 idx_ff;
   logic [IW-1:0]                 idx_in;
   logic                          last_ff;
   logic                          last_in;
   logic                          cmp_on_ff;
   logic                          cmp_on_in;
   logic [IW-1:0]                 cmp_idx_ff;
   logic [IW-1:0]                 cmp_idx_in;
   logic [JOB_SLOTS-1:0]          valid_ff;
   logic [JOB_SLOTS-1:0]          valid_in;
   logic [edf_pkg::TICK_W-1:0]    now_ff;
   logic [edf_pkg::TICK_W-1:0]    now_in;
   edf_pkg::req_type              job_ff;
   edf_pkg::req_type              job_in;
   logic                          rej_ff;
   logic                          rej_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   edf_pkg::rsp_type              rsp_ff;
   edf_pkg::rsp_type              rsp_in;

   logic                          accept;
   logic                          out_free;
   logic                          emit_load;
   logic                          ram_wr_en;
   logic [IW-1:0]                 ram_wr_addr;
   edf_pkg::slot_type             ram_wr_data;
   logic                          ram_rd_en;
   logic [IW-1:0]                 ram_rd_addr;
   edf_pkg::slot_type             ram_rd_data;
   edf_pkg::pick_ctl_type         pick_ctl;
   logic                          best_found;
   logic [IW-1:0]                 best_idx;
   edf_pkg::slot_type             best_slot;

   assign accept   = req_valid && (state_ff == edf_pkg::ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // slot storage
   edf_ram #(
      .WIDTH (edf_pkg::SLOT_W),
      .DEPTH (JOB_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // shared deadline compare unit
   edf_pick #(
      .IDX_W (IW)
   ) u_pick (
      .clock      (clock),
      .reset      (reset),
      .ctl        (pick_ctl),
      .cand_idx   (cmp_idx_ff),
      .cand       (ram_rd_data),
      .best_found (best_found),
      .best_idx   (best_idx),
      .best_slot  (best_slot)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      cmp_on_in    = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      valid_in     = valid_ff;
      now_in       = now_ff;
      job_in       = job_ff;
      rej_in       = rej_ff;
      rsp_in       = rsp_ff;
      emit_load    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff;
      ram_wr_data  = best_slot;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff;
      pick_ctl.start   = 1'b0;
      pick_ctl.cand_on = (state_ff == edf_pkg::ST_SCAN) && cmp_on_ff && valid_ff[cmp_idx_ff];

      case (state_ff)
         edf_pkg::ST_IDLE: begin
            if (accept) begin
               job_in         = req_data;
               idx_in         = '0;
               last_in        = 1'b0;
               pick_ctl.start = 1'b1;
               state_in       = (req_data.func == edf_pkg::FUNC_TICK) ?
                                edf_pkg::ST_SCAN : edf_pkg::ST_FREE;
            end
         end
         edf_pkg::ST_FREE: begin
            // lowest free slot, one valid bit per cycle
            if (!valid_ff[idx_ff]) begin
               ram_wr_en                = 1'b1;
               ram_wr_addr              = idx_ff;
               ram_wr_data.task_id      = job_ff.task_id;
               ram_wr_data.remaining    = job_ff.work_ticks;
               ram_wr_data.deadline     = job_ff.abs_deadline;
               ram_wr_data.release_tick = now_ff;
               valid_in[idx_ff]         = 1'b1;
               rej_in                   = 1'b0;
               state_in                 = edf_pkg::ST_EMIT;
            end else if (idx_ff == LAST_IDX) begin
               rej_in   = 1'b1;
               state_in = edf_pkg::ST_EMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         edf_pkg::ST_SCAN: begin
            // read one slot per cycle, compare it the cycle after
            if (!last_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff;
               cmp_on_in   = 1'b1;
               cmp_idx_in  = idx_ff;
               if (idx_ff == LAST_IDX) begin
                  last_in = 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               state_in = edf_pkg::ST_EMIT;
            end
         end
         edf_pkg::ST_EMIT: begin
            if (out_free) begin
               emit_load = 1'b1;
               rsp_in    = '0;
               state_in  = edf_pkg::ST_IDLE;
               if (job_ff.func == edf_pkg::FUNC_RELEASE) begin
                  rsp_in.rejected = rej_ff;
               end else begin
                  now_in = now_ff + 1'b1;
                  if (!best_found) begin
                     rsp_in.idle = 1'b1;
                  end else begin
                     rsp_in.served_task = best_slot.task_id;
                     rsp_in.late        = (now_ff >= best_slot.deadline);
                     if (best_slot.remaining <= edf_pkg::WORK_W'(1)) begin
                        rsp_in.job_done    = 1'b1;
                        valid_in[best_idx] = 1'b0;
                     end else begin
                        ram_wr_en             = 1'b1;
                        ram_wr_addr           = best_idx;
                        ram_wr_data           = best_slot;
                        ram_wr_data.remaining = best_slot.remaining - 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = edf_pkg::ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= edf_pkg::ST_IDLE;
         idx_ff       <= '0;
         last_ff      <= 1'b0;
         cmp_on_ff    <= 1'b0;
         valid_ff     <= '0;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         last_ff      <= last_in;
         cmp_on_ff    <= cmp_on_in;
         valid_ff     <= valid_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmp_idx_ff <= cmp_idx_in;
      job_ff     <= job_in;
      rej_ff     <= rej_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall = (state_ff != edf_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // idle and rejected beats carry no service information
   a_quiet_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.idle || rsp_ff.rejected) |->
         (rsp_ff.served_task == '0) && !rsp_ff.job_done && !rsp_ff.late)
      else $error("idle or rejected beat carries service flags");

   // a finished job frees its slot
   a_done_frees: assert property (@(posedge clock) disable iff (reset)
      emit_load && (job_ff.func == edf_pkg::FUNC_TICK) && best_found &&
         (best_slot.remaining <= edf_pkg::WORK_W'(1)) |=> !valid_ff[$past(best_idx)])
      else $error("finished job left its slot valid");

   // only a tick advances time
   a_release_no_time: assert property (@(posedge clock) disable iff (reset)
      emit_load && (job_ff.func == edf_pkg::FUNC_RELEASE) |=> $stable(now_ff))
      else $error("release moved the tick counter");

endmodule
